// ===== rtl/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg: shared types and calendar functions
// Time-of-day and date record, result record, and the Gregorian date test
// used by the tick datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;

  // Packed stream widths.
  localparam int unsigned FieldsW = DayW + MonthW + YearW + HourW + MinW + SecW;
  localparam int unsigned TdataW  = ((FieldsW + 7) / 8) * 8;
  localparam int unsigned PadW    = TdataW - FieldsW;

  localparam logic [6:0] SecLast  = 7'd59;
  localparam logic [6:0] MinLast  = 7'd59;
  localparam logic [5:0] HourLast = 6'd23;

  localparam logic [YearW-1:0] GregYear  = 16'd1582;
  localparam logic [4:0]       GregMonth = 5'd10;
  localparam logic [5:0]       GregDay   = 6'd15;
  localparam logic [4:0]       LastMonth = 5'd12;

  // Divisibility by 25: y is a multiple of 25 exactly when y times the
  // inverse of 25 modulo 2^16 falls at or below floor(65535 / 25).
  localparam logic [YearW-1:0] Div25Inv = 16'd23593;
  localparam logic [YearW-1:0] Div25Lim = 16'd2621;

  localparam logic [DayW-1:0]   RstDay   = 5'd1;
  localparam logic [MonthW-1:0] RstMonth = 4'd1;
  localparam logic [YearW-1:0]  RstYear  = 16'd2000;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_LOAD = 1'b1
  } action_e;

  typedef struct packed {
    logic [SecW-1:0]   second;
    logic [MinW-1:0]   minute;
    logic [HourW-1:0]  hour;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } rtc_t;

  typedef struct packed {
    logic date_valid;
    rtc_t now;
  } result_t;

  function automatic logic leap_year(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = y * Div25Inv;
    div25 = (prod <= Div25Lim);
    // Multiple of 400: 25 and 16. Multiple of 100: 25 and 4.
    return (div25 && (y[3:0] == 4'd0)) || (!div25 && (y[1:0] == 2'd0));
  endfunction

  function automatic logic date_ok(input logic [5:0]       d,
                                   input logic [4:0]       m,
                                   input logic [YearW-1:0] y,
                                   input logic             leap);
    logic [5:0] limit;
    logic       ok;
    case (m)
      5'd2:                      limit = leap ? 6'd29 : 6'd28;
      5'd4, 5'd6, 5'd9, 5'd11:  limit = 6'd30;
      default:                   limit = 6'd31;
    endcase
    ok = (d != 6'd0) && (m != 5'd0) && (m <= LastMonth) && (y >= GregYear);
    if ((y == GregYear) && ((m < GregMonth) || ((m == GregMonth) && (d < GregDay)))) begin
      ok = 1'b0;
    end
    return ok && (d <= limit);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cct_step.sv =====
// ----------------------------------------------------------------------------
// cct_step: next time and date for one transaction
// Applies a load or a one-second tick to the current record and reports
// whether the resulting date is a valid Gregorian date.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_step
  import cct_pkg::*;
(
  input  rtc_t    cur_i,
  input  action_e action_i,
  input  rtc_t    load_i,
  output result_t res_o
);

  logic [YearW-1:0] year_sel;
  logic             leap;
  logic [6:0]       sec_inc;
  logic [6:0]       min_inc;
  logic [5:0]       hour_inc;
  logic [5:0]       day_inc;
  logic [4:0]       month_inc;
  logic             min_ok;
  logic             hour_ok;
  rtc_t             nxt;

  // One leap test serves both paths: a tick only needs the current year,
  // and when the year rolls over the date is January 1st.
  assign year_sel = (action_i == ACT_LOAD) ? load_i.year : cur_i.year;
  assign leap     = leap_year(year_sel);

  assign sec_inc   = {1'b0, cur_i.second} + 7'd1;
  assign min_inc   = {1'b0, cur_i.minute} + 7'd1;
  assign hour_inc  = {1'b0, cur_i.hour} + 6'd1;
  assign day_inc   = {1'b0, cur_i.day} + 6'd1;
  assign month_inc = {1'b0, cur_i.month} + 5'd1;
  assign min_ok    = ({1'b0, cur_i.minute} <= MinLast);
  assign hour_ok   = ({1'b0, cur_i.hour} <= HourLast);

  always_comb begin
    nxt = cur_i;
    if (action_i == ACT_LOAD) begin
      nxt = load_i;
    end else if ((sec_inc <= SecLast) && min_ok && hour_ok) begin
      nxt.second = sec_inc[SecW-1:0];
    end else if ((min_inc <= MinLast) && hour_ok) begin
      nxt.second = '0;
      nxt.minute = min_inc[MinW-1:0];
    end else if (hour_inc <= HourLast) begin
      nxt.second = '0;
      nxt.minute = '0;
      nxt.hour   = hour_inc[HourW-1:0];
    end else begin
      nxt.second = '0;
      nxt.minute = '0;
      nxt.hour   = '0;
      if (date_ok(day_inc, {1'b0, cur_i.month}, cur_i.year, leap)) begin
        nxt.day = day_inc[DayW-1:0];
      end else if (date_ok(6'd1, month_inc, cur_i.year, leap)) begin
        nxt.day   = RstDay;
        nxt.month = month_inc[MonthW-1:0];
      end else begin
        nxt.day   = RstDay;
        nxt.month = RstMonth;
        nxt.year  = cur_i.year + 16'd1;
      end
    end
  end

  assign res_o.now        = nxt;
  assign res_o.date_valid = date_ok({1'b0, nxt.day}, {1'b0, nxt.month}, nxt.year, leap);

endmodule

`default_nettype wire

// ===== rtl/calendar_clock_tick.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_tick: real-time clock with a Gregorian calendar
// Keeps second, minute, hour, day, month and year; ticks or loads per
// transaction and returns the new values with a date validity flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tuser selects the action (0 ticks one second,
//   1 loads all six fields from s_axis_tdata). Output stream: one
//   transaction per input transaction, carrying the updated time and date
//   on m_axis_tdata and the date validity flag on m_axis_tuser.
//   The result of an accepted transaction is registered in the result
//   register, or in the skid register while a result waits. Throughput is
//   one transaction per cycle while s_axis_tready is high. A two-entry
//   output buffer (result register plus skid register) lets the block take
//   one more transaction while a result waits; s_axis_tready drops only
//   when both hold results, and rises again once the receiver takes one.
//   Reset sets 00:00:00 on 1 January 2000 and empties the output buffer;
//   no result is produced by the reset itself.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_tick
  import cct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // load_day, load_month, load_year, load_hour, load_minute, load_second, pad
  input  logic [TdataW-1:0] s_axis_tdata,
  // action
  input  logic [0:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // day, month, year, hour, minute, second, pad
  output logic [TdataW-1:0] m_axis_tdata,
  // date_valid
  output logic [0:0]        m_axis_tuser
);

  rtc_t    state_q;
  rtc_t    load;
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    in_take;
  logic    out_take;

  assign load     = rtc_t'(s_axis_tdata[FieldsW-1:0]);
  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_take = out_valid_q && m_axis_tready;

  cct_step u_step (
    .cur_i    (state_q),
    .action_i (action_e'(s_axis_tuser[0])),
    .load_i   (load),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= {{SecW{1'b0}}, {MinW{1'b0}}, {HourW{1'b0}}, RstYear, RstMonth, RstDay};
    end else if (in_take) begin
      state_q <= res.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_take) begin
      out_valid_q <= 1'b1;
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers: the skid entry always holds the newer result.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_take) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign s_axis_tready   = !skid_valid_q;
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {{PadW{1'b0}}, out_q.now};
  assign m_axis_tuser[0] = out_q.date_valid;

endmodule

`default_nettype wire

// ===== rtl/cct_checker.sv =====
// ----------------------------------------------------------------------------
// cct_checker: port-level checks for calendar_clock_tick
// Watches the stream ports for buffer and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_checker
  import cct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [TdataW-1:0] m_axis_tdata,
  input  logic [0:0]        m_axis_tuser
);

  rtc_t shown;
  assign shown = rtc_t'(m_axis_tdata[FieldsW-1:0]);

  // The input only stalls while results are waiting.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // After an accepted transaction, a result is always offered on the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

  // A stalled result holds its payload.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // A date with month or day zero is never reported valid.
  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((shown.month == '0) || (shown.day == '0))) |-> !m_axis_tuser[0])
    else $error("date with zero field flagged valid");

  // Padding bits above the fields stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[TdataW-1:FieldsW] == '0))
    else $error("result padding not zero");

endmodule

bind calendar_clock_tick cct_checker u_cct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
